// File: hw/rtl/fcpp_pkg.sv
// Package for the framed command packet parser.
// Holds the parse phase encoding, the frame handoff struct and register constants.
// No dependencies.
package fcpp_pkg;

	localparam int unsigned PAYLOAD_BYTES = 3;
	localparam int unsigned CNT_W         = 2;
	localparam int unsigned WORD_W        = PAYLOAD_BYTES * 8;
	localparam int unsigned DIST_W        = 14;
	localparam int unsigned ANGLE_W       = 8;
	localparam int unsigned SDIST_W       = DIST_W + 1;
	localparam int unsigned OUT_TDATA_W   = 40;
	localparam int unsigned PADDR_W       = 3;

	localparam logic [7:0] START_MARKER_RST = 8'hAA;
	localparam logic [7:0] END_MARKER_RST   = 8'h55;

	// register index, taken from paddr[2]
	localparam logic REG_START_MARKER = 1'b0;
	localparam logic REG_END_MARKER   = 1'b1;

	typedef enum logic [3:0] {
		PH_START   = 4'b0001,
		PH_PAYLOAD = 4'b0010,
		PH_CHECK   = 4'b0100,
		PH_END     = 4'b1000
	} phase_t;

	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] word;
	} frame_t;

endpackage

// File: hw/rtl/fcpp_parser.sv
// Frame parser: phase, payload store, count and running XOR.
// Emits one frame_t per byte step; valid on a good end marker.
// Depends on fcpp_pkg.
module fcpp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          start_marker,
	input  logic [7:0]          end_marker,
	output fcpp_pkg::frame_t    frame
);

	fcpp_pkg::phase_t                phase_q, phase_d;
	logic [fcpp_pkg::CNT_W-1:0]      count_q, count_d;
	logic [7:0]                      xor_q, xor_d;
	logic [7:0]                      store_q [fcpp_pkg::PAYLOAD_BYTES];
	logic                            store_we;

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		xor_d    = xor_q;
		store_we = 1'b0;
		case (phase_q)
			fcpp_pkg::PH_START: begin
				if (rx_byte == start_marker) begin
					count_d = '0;
					xor_d   = '0;
					phase_d = fcpp_pkg::PH_PAYLOAD;
				end
			end
			fcpp_pkg::PH_PAYLOAD: begin
				store_we = 1'b1;
				xor_d    = xor_q ^ rx_byte;
				count_d  = count_q + 1'b1;
				if (count_q == fcpp_pkg::CNT_W'(fcpp_pkg::PAYLOAD_BYTES - 1))
					phase_d = fcpp_pkg::PH_CHECK;
			end
			fcpp_pkg::PH_CHECK: begin
				phase_d = (rx_byte == xor_q) ? fcpp_pkg::PH_END : fcpp_pkg::PH_START;
			end
			default: begin
				phase_d = fcpp_pkg::PH_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fcpp_pkg::PH_START;
			count_q <= '0;
			xor_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			xor_q   <= xor_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && store_we) begin
			store_q[count_q] <= rx_byte;
		end
	end

	assign frame.valid = step && (phase_q == fcpp_pkg::PH_END) && (rx_byte == end_marker);
	assign frame.word  = {store_q[0], store_q[1], store_q[2]};

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == fcpp_pkg::PH_PAYLOAD |-> count_q != 2'd3)
		else $error("payload count out of range");

	a_check_after_payload: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == fcpp_pkg::PH_PAYLOAD && count_q == 2'd2
		|=> phase_q == fcpp_pkg::PH_CHECK)
		else $error("payload did not advance to checksum");

	a_end_returns: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == fcpp_pkg::PH_END |=> phase_q == fcpp_pkg::PH_START)
		else $error("end phase did not return to start");

	a_start_opens: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == fcpp_pkg::PH_START && rx_byte == start_marker
		|=> phase_q == fcpp_pkg::PH_PAYLOAD && count_q == '0 && xor_q == '0)
		else $error("start marker did not open a frame");

endmodule

// File: hw/rtl/fcpp_result.sv
// Result stage: splits the payload word, forms the signed distance and
// holds the result in the output register. Depends on fcpp_pkg.
module fcpp_result (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fcpp_pkg::frame_t                    frame,
	output logic                                advance,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fcpp_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	logic                                valid_q;
	logic [fcpp_pkg::OUT_TDATA_W-1:0]    data_q;
	logic                                cmd, dir;
	logic [fcpp_pkg::DIST_W-1:0]         dist_mag;
	logic [fcpp_pkg::ANGLE_W-1:0]        angle;
	logic [fcpp_pkg::SDIST_W-1:0]        sdist;

	assign cmd      = frame.word[23];
	assign dir      = frame.word[22];
	assign dist_mag = frame.word[21:8];
	assign angle    = frame.word[7:0];
	assign sdist    = dir ? (fcpp_pkg::SDIST_W'(0) - {1'b0, dist_mag}) : {1'b0, dist_mag};

	assign advance = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame.valid) begin
			data_q <= {1'b0, sdist, angle, dist_mag, dir, cmd};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

// File: hw/rtl/framed_command_packet_parser_core.sv
// The closing end byte is held in the byte stage register, then the result register drives m_tvalid.
// Throughput: one byte per cycle; the output register stalls the byte stage
// only while a result waits on m_tready.
// Reset (arst_n low): parser waits for start, count and XOR cleared, output empty,
// markers return to 0xAA (start) and 0x55 (end).
// Top level; uses fcpp_pkg, fcpp_parser, fcpp_result.
module framed_command_packet_parser_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [0] command_flag, [1] direction_flag, [15:2] distance_magnitude,
	// [23:16] angle_value, [38:24] signed_distance, [39] zero
	output logic [fcpp_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fcpp_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	logic [7:0]         start_marker_q, end_marker_q;
	logic               byte_valid_s1;
	logic [7:0]         byte_s1;
	logic               advance, step;
	fcpp_pkg::frame_t   frame;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= fcpp_pkg::START_MARKER_RST;
			end_marker_q   <= fcpp_pkg::END_MARKER_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == fcpp_pkg::REG_START_MARKER)
				start_marker_q <= pwdata[7:0];
			else
				end_marker_q <= pwdata[7:0];
		end
	end

	assign prdata = {24'd0, (paddr[2] == fcpp_pkg::REG_END_MARKER) ? end_marker_q
	                                                               : start_marker_q};

	assign step     = byte_valid_s1 && advance;
	assign s_tready = !byte_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			byte_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	fcpp_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.rx_byte      (byte_s1),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.frame        (frame)
	);

	fcpp_result u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: tb/framed_command_packet_parser_core_test.sv
// Testbench for framed_command_packet_parser_core: byte stream in, decoded move commands out.
// A predictor mirrors the parser and markers, and a checker compares each result transfer.
// Depends on fcpp_pkg and the RTL of the core.
`timescale 1ns / 1ps

module framed_command_packet_parser_core_test;

	localparam int unsigned IDLE_LIMIT = 1000;
	localparam int unsigned MAX_PRINTS = 40;

	typedef struct {
		logic        cmd;
		logic        dir;
		logic [13:0] dist_mag;
		logic [7:0]  angle;
		logic [14:0] sdist;
	} move_cmd_t;

	typedef enum int {
		FR_GOOD,
		FR_BAD_SUM,
		FR_BAD_END,
		FR_NOISE
	} frame_kind_t;

	logic                   clk;
	logic                   arst_n  = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata = 8'h00;  // [7:0] rx_byte
	logic                   m_tvalid;
	logic                   m_tready = 1'b1;
	// [0] command_flag, [1] direction_flag, [15:2] distance_magnitude,
	// [23:16] angle_value, [38:24] signed_distance, [39] zero
	logic [fcpp_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                   psel    = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite  = 1'b0;
	logic [fcpp_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0]            pwdata  = '0;
	logic [31:0]            prdata;
	logic                   pready;

	// predictor state
	logic [7:0] mirror_start = fcpp_pkg::START_MARKER_RST;
	logic [7:0] mirror_end   = fcpp_pkg::END_MARKER_RST;
	fcpp_pkg::phase_t parse_ph = fcpp_pkg::PH_START;
	logic [7:0] pay_buf [0:2];
	logic [1:0] pay_cnt      = '0;
	logic [7:0] pay_xor      = '0;
	move_cmd_t  moves_due [$];

	int         errors      = 0;
	int         idle_cycles = 0;
	int         burst_left  = 0;
	bit         sender_steady = 1'b1;
	bit         rx_throttle   = 1'b0;
	int         hold_cnt      = 0;

	framed_command_packet_parser_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_error(input string msg);
		if (errors < MAX_PRINTS)
			$display("ERROR %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic track_byte(input logic [7:0] b);
		move_cmd_t mv;
		case (parse_ph)
			fcpp_pkg::PH_START: begin
				if (b == mirror_start) begin
					pay_cnt  = '0;
					pay_xor  = '0;
					parse_ph = fcpp_pkg::PH_PAYLOAD;
				end
			end
			fcpp_pkg::PH_PAYLOAD: begin
				pay_buf[pay_cnt] = b;
				pay_xor = pay_xor ^ b;
				pay_cnt = pay_cnt + 2'd1;
				if (pay_cnt == fcpp_pkg::PAYLOAD_BYTES)
					parse_ph = fcpp_pkg::PH_CHECK;
			end
			fcpp_pkg::PH_CHECK: begin
				parse_ph = (b == pay_xor) ? fcpp_pkg::PH_END : fcpp_pkg::PH_START;
			end
			default: begin
				parse_ph = fcpp_pkg::PH_START;
				if (b == mirror_end) begin
					mv.cmd      = pay_buf[0][7];
					mv.dir      = pay_buf[0][6];
					mv.dist_mag = {pay_buf[0][5:0], pay_buf[1]};
					mv.angle    = pay_buf[2];
					mv.sdist    = {1'b0, mv.dist_mag};
					if (mv.dir)
						mv.sdist = -mv.sdist;
					moves_due.push_back(mv);
				end
			end
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (!sender_steady && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		track_byte(b);
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic wait_idle();
		@(negedge clk) s_tvalid <= 1'b0;
		while (moves_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic reg_sel, input logic [31:0] val);
		@(negedge clk);
		s_tvalid <= 1'b0;
		psel     <= 1'b1;
		penable  <= 1'b0;
		pwrite   <= 1'b1;
		paddr    <= {reg_sel, 2'b00};
		pwdata   <= val;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_sel == fcpp_pkg::REG_START_MARKER)
			mirror_start = val[7:0];
		else
			mirror_end = val[7:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_check(input logic reg_sel);
		logic [7:0] want;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {reg_sel, 2'b00};
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		want = (reg_sel == fcpp_pkg::REG_START_MARKER) ? mirror_start : mirror_end;
		if (prdata[7:0] !== want)
			report_error($sformatf("register %0d read %0h, want %0h", reg_sel, prdata[7:0],
				want));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_markers(input logic [7:0] start_v, input logic [7:0] end_v);
		wait_idle();
		apb_write(fcpp_pkg::REG_START_MARKER, {24'($urandom), start_v});
		apb_write(fcpp_pkg::REG_END_MARKER, {24'($urandom), end_v});
		apb_check(fcpp_pkg::REG_START_MARKER);
		apb_check(fcpp_pkg::REG_END_MARKER);
	endtask

	function automatic logic [7:0] rand_payload();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_frame(input frame_kind_t kind);
		logic [7:0] p0, p1, p2, sum, tail;
		int n;
		if (kind == FR_NOISE) begin
			n = $urandom_range(1, 4);
			repeat (n) send_byte(8'($urandom));
			return;
		end
		p0  = rand_payload();
		p1  = rand_payload();
		p2  = rand_payload();
		sum = p0 ^ p1 ^ p2;
		tail = mirror_end;
		if (kind == FR_BAD_SUM) begin
			if ($urandom_range(0, 2) == 0 && mirror_start != sum)
				sum = mirror_start;
			else
				sum = sum ^ 8'($urandom_range(1, 255));
		end else if (kind == FR_BAD_END) begin
			if ($urandom_range(0, 2) == 0 && mirror_start != mirror_end)
				tail = mirror_start;
			else
				tail = mirror_end ^ 8'($urandom_range(1, 255));
		end
		send_byte(mirror_start);
		send_byte(p0);
		send_byte(p1);
		send_byte(p2);
		send_byte(sum);
		send_byte(tail);
	endtask

	task automatic test_reset_values();
		apb_check(fcpp_pkg::REG_START_MARKER);
		apb_check(fcpp_pkg::REG_END_MARKER);
	endtask

	task automatic test_directed_frames();
		logic [7:0] seq [$];
		logic [7:0] sm, em;
		sm = fcpp_pkg::START_MARKER_RST;
		em = fcpp_pkg::END_MARKER_RST;
		sender_steady = 1'b1;
		rx_throttle   = 1'b0;
		// ignored byte, then direction set with zero distance
		seq = {8'h00, sm, 8'h40, 8'h00, 8'hFF, 8'hBF, em};
		// all flags and full distance
		seq = {seq, sm, 8'hFF, 8'hFF, 8'h00, 8'h00, em};
		// wrong checksum equal to the start marker, then a stray end byte
		seq = {seq, sm, 8'h01, 8'h02, 8'h03, sm, em};
		// wrong end byte equal to the start marker
		seq = {seq, sm, 8'h80, 8'h00, 8'h00, 8'h80, sm};
		foreach (seq[k])
			send_byte(seq[k]);
		wait_idle();
	endtask

	task automatic test_random_traffic(input logic [7:0] start_v, input logic [7:0] end_v,
		input bit steady, input bit throttle, input int nbytes);
		int sent_before;
		int r;
		set_markers(start_v, end_v);
		sender_steady = steady;
		rx_throttle   = throttle;
		burst_left    = 0;
		sent_before   = 0;
		while (sent_before < nbytes) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				send_frame(FR_GOOD);
			else if (r < 80)
				send_frame(FR_BAD_SUM);
			else if (r < 90)
				send_frame(FR_BAD_END);
			else
				send_frame(FR_NOISE);
			sent_before += (r < 90) ? 6 : 2;
		end
		wait_idle();
	endtask

	always @(negedge clk) begin
		if (!rx_throttle) begin
			m_tready <= 1'b1;
		end else if (hold_cnt != 0) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if ($urandom_range(0, 15) == 0) begin
			m_tready <= 1'b0;
			hold_cnt <= $urandom_range(1, 24);
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		move_cmd_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (moves_due.size() == 0) begin
				report_error($sformatf("unexpected result %h", m_tdata));
			end else begin
				want = moves_due.pop_front();
				if (m_tdata[0] !== want.cmd)
					report_error($sformatf("command_flag %b, want %b", m_tdata[0], want.cmd));
				if (m_tdata[1] !== want.dir)
					report_error($sformatf("direction_flag %b, want %b", m_tdata[1], want.dir));
				if (m_tdata[15:2] !== want.dist_mag)
					report_error($sformatf("distance_magnitude %0h, want %0h", m_tdata[15:2],
						want.dist_mag));
				if (m_tdata[23:16] !== want.angle)
					report_error($sformatf("angle_value %0h, want %0h", m_tdata[23:16],
						want.angle));
				if (m_tdata[38:24] !== want.sdist)
					report_error($sformatf("signed_distance %0h, want %0h", m_tdata[38:24],
						want.sdist));
				if (m_tdata[39] !== 1'b0)
					report_error("m_tdata pad bit not zero");
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_directed_frames();
		test_random_traffic(8'hAA, 8'h55, 1'b1, 1'b0, 150);
		test_random_traffic(8'h00, 8'hFF, 1'b0, 1'b1, 150);
		test_random_traffic(8'hFF, 8'h00, 1'b0, 1'b1, 150);
		test_random_traffic(8'h5A, 8'h5A, 1'b0, 1'b0, 120);
		test_random_traffic(8'($urandom), 8'($urandom), 1'b1, 1'b1, 150);
		test_random_traffic(8'hAA, 8'h55, 1'b0, 1'b1, 200);
		wait_idle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
